// ----- src/dado_pkg.sv -----
// Shared types, register indexes and calendar constants for the date shifter.
package dado_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned LEAD_W  = 10;
    localparam int unsigned CFG_IDX_W = 1;
    // Working day count: day plus or minus lead, kept as a signed value.
    localparam int unsigned DACC_W  = 12;

    localparam logic [CFG_IDX_W-1:0] REG_LEAD_DAYS      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_BACKWARD = 1'd1;

    localparam logic [LEAD_W-1:0]  LEAD_DAYS_RESET      = 10'd54;
    localparam logic               COUNT_BACKWARD_RESET = 1'b0;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 12'd0;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 12'd4095;

    localparam logic [DAY_W-1:0] FEB_LONG  = 5'd29;
    localparam logic [DAY_W-1:0] FEB_SHORT = 5'd28;
    localparam logic [DAY_W-1:0] DAYS_MAX  = 5'd31;

    localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } dado_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_more;
        logic err;
    } dado_stat_t;

    // Length of month m in year y; leap year when y mod 4 is zero.
    function automatic logic [DAY_W-1:0] month_len(
        input logic [MONTH_W-1:0] m,
        input logic [YEAR_W-1:0]  y
    );
        logic [DAY_W-1:0] len;
        if (m == MONTH_FEB)
            len = (y[1:0] == 2'd0) ? FEB_LONG : FEB_SHORT;
        else if (m > MONTH_DEC)
            len = DAYS_MAX;
        else
            len = MONTH_DAYS[m];
        return len;
    endfunction

endpackage

// ----- src/dado_datapath.sv -----
// Datapath of the date shifter: input check, month walk and output register.
module dado_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dado_pkg::dado_cmd_t                cmd,
    output dado_pkg::dado_stat_t               stat,
    input  logic [dado_pkg::LEAD_W-1:0]        lead_days,
    input  logic                               count_backward,
    input  logic [dado_pkg::DAY_W-1:0]         day_in,
    input  logic [dado_pkg::MONTH_W-1:0]       month_in,
    input  logic [dado_pkg::YEAR_W-1:0]        year_in,
    output logic [dado_pkg::DAY_W-1:0]         day_out,
    output logic [dado_pkg::MONTH_W-1:0]       month_out,
    output logic [dado_pkg::YEAR_W-1:0]        year_out,
    output logic                               date_error
);
    import dado_pkg::*;

    logic signed [DACC_W-1:0] d_reg, d_next;
    logic [MONTH_W-1:0]       m_reg, m_next;
    logic [YEAR_W-1:0]        y_reg, y_next;
    logic                     err_reg, err_next;
    logic                     back_reg;
    logic [DAY_W-1:0]         d0_reg;
    logic [MONTH_W-1:0]       m0_reg;
    logic [YEAR_W-1:0]        y0_reg;

    logic [DAY_W-1:0]         day_out_reg;
    logic [MONTH_W-1:0]       month_out_reg;
    logic [YEAR_W-1:0]        year_out_reg;
    logic                     date_error_reg;

    logic [DAY_W-1:0]         len_in;
    logic                     bad_in;
    logic [DACC_W-1:0]        day_ext, lead_ext;
    logic [DAY_W-1:0]         len_cur, len_prev;
    logic [MONTH_W-1:0]       m_prev;
    logic [YEAR_W-1:0]        y_prev;

    // Check the incoming date.
    assign len_in   = month_len(month_in, year_in);
    assign bad_in   = (month_in > MONTH_DEC) || (day_in == '0) || (day_in > len_in);
    assign day_ext  = {{(DACC_W-DAY_W){1'b0}}, day_in};
    assign lead_ext = {{(DACC_W-LEAD_W){1'b0}}, lead_days};

    // Current month and the one before it.
    assign len_cur  = month_len(m_reg, y_reg);
    assign m_prev   = (m_reg == MONTH_JAN) ? MONTH_DEC : m_reg - 1'b1;
    assign y_prev   = (m_reg == MONTH_JAN) ? y_reg - 1'b1 : y_reg;
    assign len_prev = month_len(m_prev, y_prev);

    always_comb
    begin
        if (back_reg)
            stat.walk_more = (d_reg < $signed(DACC_W'(1)));
        else
            stat.walk_more = (d_reg > $signed({{(DACC_W-DAY_W){1'b0}}, len_cur}));
        stat.err = err_reg;
    end

    always_comb
    begin
        d_next   = d_reg;
        m_next   = m_reg;
        y_next   = y_reg;
        err_next = err_reg;
        if (cmd.load)
        begin
            d_next   = count_backward ? $signed(day_ext - lead_ext)
                                      : $signed(day_ext + lead_ext);
            m_next   = month_in;
            y_next   = year_in;
            err_next = bad_in;
        end
        else if (cmd.step)
        begin
            if (!back_reg)
            begin
                // Drop one month and advance, carrying into the year.
                d_next = d_reg - $signed({{(DACC_W-DAY_W){1'b0}}, len_cur});
                if (m_reg == MONTH_DEC)
                begin
                    if (y_reg == YEAR_MAX)
                        err_next = 1'b1;
                    else
                    begin
                        m_next = MONTH_JAN;
                        y_next = y_reg + 1'b1;
                    end
                end
                else
                    m_next = m_reg + 1'b1;
            end
            else
            begin
                // Step back one month and add its length.
                if (m_reg == MONTH_JAN && y_reg == YEAR_MIN)
                    err_next = 1'b1;
                else
                begin
                    m_next = m_prev;
                    y_next = y_prev;
                    d_next = d_reg + $signed({{(DACC_W-DAY_W){1'b0}}, len_prev});
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg   <= '0;
            m_reg   <= MONTH_JAN;
            y_reg   <= YEAR_MIN;
            err_reg <= 1'b1;
        end
        else
        begin
            d_reg   <= d_next;
            m_reg   <= m_next;
            y_reg   <= y_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d0_reg   <= day_in;
            m0_reg   <= month_in;
            y0_reg   <= year_in;
            back_reg <= count_backward;
        end
        if (cmd.emit)
        begin
            day_out_reg    <= err_reg ? d0_reg : d_reg[DAY_W-1:0];
            month_out_reg  <= err_reg ? m0_reg : m_reg;
            year_out_reg   <= err_reg ? y0_reg : y_reg;
            date_error_reg <= err_reg;
        end
    end

    assign day_out    = day_out_reg;
    assign month_out  = month_out_reg;
    assign year_out   = year_out_reg;
    assign date_error = date_error_reg;

    a_month_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !err_reg |-> (m_reg <= MONTH_DEC))
        else $error("month left range without error");

    a_emit_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !err_reg) |->
            (d_reg >= $signed(DACC_W'(1)) &&
             d_reg <= $signed({{(DACC_W-DAY_W){1'b0}}, len_cur})))
        else $error("emitted day outside month");

endmodule

// ----- src/dado_ctrl.sv -----
// Controller of the date shifter: accept, walk and emit sequencing.
module dado_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dado_pkg::dado_cmd_t   cmd,
    input  dado_pkg::dado_stat_t  stat
);
    import dado_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   walk_end;

    assign walk_end = stat.err || !stat.walk_more;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load = in_valid && (state_reg == ST_IDLE);
        cmd.step = (state_reg == ST_WALK) && !walk_end;
        cmd.emit = (state_reg == ST_WALK) && walk_end && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.load)
                        state_reg <= ST_WALK;
                end
                ST_WALK:
                begin
                    if (cmd.emit)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result word overwritten");

    a_load_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && (cmd.step || cmd.emit)))
        else $error("load overlaps walk");

    a_load_then_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_WALK && !out_valid_reg) || out_valid_reg)
        else $error("load did not start walk");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("emit did not present result");

endmodule

// ----- src/date_add_day_offset.sv -----
// Top level of the date shifter: configuration registers and unit wiring.
//
// Moves a calendar date (day, month 0..11, year 0..4095) forward or back
// by lead_days days, with February of 29 days in years divisible by four.
// Input words arrive on in_valid/in_ready with day_in, month_in, year_in;
// results leave on out_valid/out_ready with day_out, month_out, year_out
// and date_error. An invalid date or a walk beyond year 4095 or before
// year 0 sets date_error and echoes the input date.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 lead_days,
// 1 count_backward) and cfg_data; cfg_ready is always high. Write only
// while the block is idle.
// Sequence: the word is taken, the walk steps one month at a time, and the
// output register is then loaded, waiting while it still holds a result
// that the receiver has not taken. One word is in work at a time, and the
// next word is taken once the result is in the output register, even if
// the receiver stalls it there.
// Reset sets lead_days to 54, count_backward to 0 and empties the output.
module date_add_day_offset (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dado_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dado_pkg::LEAD_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [dado_pkg::DAY_W-1:0]         day_in,
    input  logic [dado_pkg::MONTH_W-1:0]       month_in,
    input  logic [dado_pkg::YEAR_W-1:0]        year_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [dado_pkg::DAY_W-1:0]         day_out,
    output logic [dado_pkg::MONTH_W-1:0]       month_out,
    output logic [dado_pkg::YEAR_W-1:0]        year_out,
    output logic                               date_error
);
    import dado_pkg::*;

    logic [LEAD_W-1:0] lead_days_reg;
    logic              count_backward_reg;
    dado_cmd_t         cmd;
    dado_stat_t        stat;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_days_reg      <= LEAD_DAYS_RESET;
            count_backward_reg <= COUNT_BACKWARD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LEAD_DAYS:      lead_days_reg      <= cfg_data;
                REG_COUNT_BACKWARD: count_backward_reg <= cfg_data[0];
                default:
                begin
                    lead_days_reg <= lead_days_reg;
                end
            endcase
        end
    end

    // Sequencing: accept a word, walk months, hand the result over.
    dado_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Working registers, month table lookups and the output register.
    dado_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .lead_days      (lead_days_reg),
        .count_backward (count_backward_reg),
        .day_in         (day_in),
        .month_in       (month_in),
        .year_in        (year_in),
        .day_out        (day_out),
        .month_out      (month_out),
        .year_out       (year_out),
        .date_error     (date_error)
    );

endmodule
